// ===== src/edtf_pkg.sv =====
// Package for the edit distance threshold filter.
// Holds the shared types, the cost constants and the saturating increment.
// Has no dependencies; the cell, the top and the checker refer to it by scoped names.
package edtf_pkg;

    localparam int SYM_W  = 8;
    localparam int COST_W = 8;
    localparam int NUM_W  = 16;

    localparam logic [COST_W-1:0] COST_MAX           = 8'hFF;
    localparam logic [COST_W-1:0] STEP_COST          = 8'd1;
    localparam logic [COST_W-1:0] MAX_DISTANCE_RESET = 8'd2;

    typedef enum logic {
        KIND_QUERY = 1'b0,
        KIND_DICT  = 1'b1
    } kind_t;

    // One dictionary symbol travelling along the row of cells.
    typedef struct packed {
        logic              valid;
        logic              start;        // first symbol of a word: use the initial row
        logic              last;
        logic [SYM_W-1:0]  sym;
        logic [COST_W-1:0] new_cost;     // updated cost of the sending cell
        logic [COST_W-1:0] old_cost;     // cost of the sending cell before the update
        logic [COST_W-1:0] result_cost;  // cost captured at the query length
    } token_t;

    function automatic logic [COST_W-1:0] sat_inc(input logic [COST_W-1:0] v);
        return (v == COST_MAX) ? COST_MAX : v + STEP_COST;
    endfunction

endpackage

// ===== src/edtf_in_if.sv =====
// Input channel of the edit distance threshold filter: valid/ready plus payload.
// Depends on nothing; field widths follow the package constants in value.
interface edtf_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, kind, symbol, last, input ready);
    modport sink   (input valid, kind, symbol, last, output ready);
endinterface

// ===== src/edtf_out_if.sv =====
// Result channel of the edit distance threshold filter: valid/ready plus payload.
// Depends on nothing.
interface edtf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  distance;
    logic        within_limit;
    logic [15:0] word_number;
    logic        query_too_long;

    modport source (output valid, distance, within_limit, word_number, query_too_long,
                    input ready);
    modport sink   (input valid, distance, within_limit, word_number, query_too_long,
                    output ready);
endinterface

// ===== src/edtf_cell.sv =====
// One cell of the cost row: holds one query symbol and one cost entry.
// Depends on edtf_pkg for the token type and the saturating increment.
module edtf_cell #(
    parameter int IDX   = 1,
    parameter int LEN_W = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            q_we,
    input  logic [LEN_W-1:0]                q_idx,
    input  logic [edtf_pkg::SYM_W-1:0]      q_sym,
    input  logic [LEN_W-1:0]                len,
    input  edtf_pkg::token_t                tok_in,
    output edtf_pkg::token_t                tok_out
);

    localparam logic [edtf_pkg::COST_W-1:0] INIT =
        (IDX > 255) ? edtf_pkg::COST_MAX : edtf_pkg::COST_W'(IDX);
    localparam logic [LEN_W-1:0] Q_IDX  = LEN_W'(IDX - 1);
    localparam logic [LEN_W-1:0] MY_LEN = LEN_W'(IDX);

    logic [edtf_pkg::SYM_W-1:0]  q_reg;
    logic [edtf_pkg::COST_W-1:0] cost_reg;
    edtf_pkg::token_t            tok_reg;
    edtf_pkg::token_t            tok_next;

    logic [edtf_pkg::COST_W-1:0] up;
    logic [edtf_pkg::COST_W-1:0] best;
    logic [edtf_pkg::COST_W-1:0] cost_next;

    always_comb
    begin
        up   = tok_in.start ? INIT : cost_reg;
        best = tok_in.old_cost;
        if (tok_in.new_cost < best)
        begin
            best = tok_in.new_cost;
        end
        if (up < best)
        begin
            best = up;
        end
        // A matching symbol takes the diagonal cost unchanged.
        if (q_reg == tok_in.sym)
        begin
            cost_next = tok_in.old_cost;
        end
        else
        begin
            cost_next = edtf_pkg::sat_inc(best);
        end

        tok_next             = tok_in;
        tok_next.new_cost    = cost_next;
        tok_next.old_cost    = up;
        tok_next.result_cost = (len == MY_LEN) ? cost_next : tok_in.result_cost;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && tok_in.valid)
        begin
            cost_reg <= cost_next;
        end
        if (q_we && (q_idx == Q_IDX))
        begin
            q_reg <= q_sym;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== src/edit_distance_threshold_filter_top.sv =====
// A word's result passes the head stage, the row of cells and then the output register.
// Throughput: one dictionary symbol per cycle unless the output stalls, set by the row of
// MAX_QUERY cells walked one cell per cycle; a query symbol waits until that row is empty.
// Reset (rst_n, asynchronous, active low): empty row and query, max_distance = 2.
// Depends on edtf_pkg, edtf_in_if, edtf_out_if and edtf_cell.
module edit_distance_threshold_filter_top #(
    parameter int MAX_QUERY = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    edtf_in_if.sink       items,
    edtf_out_if.source    results,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata
);

    // Query length runs from zero to MAX_QUERY inclusive.
    localparam int LEN_W = $clog2(MAX_QUERY + 1);

    // Configuration register.
    logic [7:0] max_distance_reg;

    // Query state. The query symbols themselves live in the cells.
    logic [LEN_W-1:0] qlen_reg, qlen_next;
    logic             closed_reg, closed_next;
    logic             overflow_reg, overflow_next;
    logic             word_open_reg, word_open_next;
    logic [edtf_pkg::NUM_W-1:0] word_cnt_reg, word_cnt_next;

    // Column zero of the cost row and the head stage of the chain.
    logic [edtf_pkg::COST_W-1:0] cost0_reg;
    edtf_pkg::token_t            head_tok;
    edtf_pkg::token_t            head_tok_reg;
    logic [edtf_pkg::COST_W-1:0] old0;
    logic [edtf_pkg::COST_W-1:0] new0;

    // Output register.
    logic                        out_valid_reg, out_valid_next;
    logic [edtf_pkg::COST_W-1:0] out_dist_reg;
    logic                        out_within_reg;
    logic [edtf_pkg::NUM_W-1:0]  out_num_reg;
    logic                        out_long_reg;

    // Chain of tokens: entry 0 is the head stage, entry i the output of cell i.
    edtf_pkg::token_t tok [MAX_QUERY+1];
    logic [MAX_QUERY:0] busy;
    logic               chain_empty;
    edtf_pkg::token_t   tail;

    logic             adv;
    logic             acc;
    logic             q_acc;
    logic             d_acc;
    logic             capture;
    logic [LEN_W-1:0] eff_len;
    logic             q_fits;
    logic             q_we;

    // The whole chain advances together whenever the output register can take a result,
    // so a stalled result freezes every transaction in flight without losing any.
    assign adv         = !out_valid_reg || results.ready;
    assign chain_empty = ~|busy;
    assign tail        = tok[MAX_QUERY];
    assign capture     = adv && tail.valid && tail.last;

    // Dictionary symbols flow in every cycle that adv is high; a query symbol rewrites the
    // cells, so it is held back until no dictionary transaction is left in the chain.
    assign items.ready = adv && ((items.kind == edtf_pkg::KIND_DICT) || chain_empty);
    assign acc         = items.valid && items.ready;
    assign q_acc       = acc && (items.kind == edtf_pkg::KIND_QUERY);
    assign d_acc       = acc && (items.kind == edtf_pkg::KIND_DICT);

    // A query symbol after a closed query starts a new one at position zero.
    assign eff_len = closed_reg ? '0 : qlen_reg;
    assign q_fits  = eff_len < LEN_W'(MAX_QUERY);
    assign q_we    = q_acc && q_fits;

    always_comb
    begin
        qlen_next      = qlen_reg;
        closed_next    = closed_reg;
        overflow_next  = overflow_reg;
        word_open_next = word_open_reg;
        word_cnt_next  = word_cnt_reg;

        if (q_acc)
        begin
            word_open_next = 1'b0;
            qlen_next      = eff_len;
            if (closed_reg)
            begin
                overflow_next = 1'b0;
                word_cnt_next = '0;
            end
            if (q_fits)
            begin
                qlen_next = eff_len + LEN_W'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
            closed_next = items.last;
        end
        else if (d_acc)
        begin
            // A dictionary symbol closes any query still being loaded.
            closed_next    = 1'b1;
            word_open_next = !items.last;
        end

        // Results are numbered as they leave the chain; a new query can only start
        // once the chain is empty, so this never coincides with the clear above.
        if (capture)
        begin
            word_cnt_next = word_cnt_reg + edtf_pkg::NUM_W'(1);
        end
    end

    // Column zero simply counts the symbols of the word, saturating.
    always_comb
    begin
        old0                 = word_open_reg ? cost0_reg : '0;
        new0                 = edtf_pkg::sat_inc(old0);
        head_tok.valid       = d_acc;
        head_tok.start       = !word_open_reg;
        head_tok.last        = items.last;
        head_tok.sym         = items.symbol;
        head_tok.new_cost    = new0;
        head_tok.old_cost    = old0;
        head_tok.result_cost = (qlen_reg == '0) ? new0 : '0;
    end

    assign out_valid_next = adv ? (tail.valid && tail.last) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_distance_reg <= edtf_pkg::MAX_DISTANCE_RESET;
            qlen_reg         <= '0;
            closed_reg       <= 1'b1;
            overflow_reg     <= 1'b0;
            word_open_reg    <= 1'b0;
            word_cnt_reg     <= '0;
            head_tok_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_distance_reg <= cfg_wdata;
            end
            qlen_reg      <= qlen_next;
            closed_reg    <= closed_next;
            overflow_reg  <= overflow_next;
            word_open_reg <= word_open_next;
            word_cnt_reg  <= word_cnt_next;
            if (adv)
            begin
                head_tok_reg <= head_tok;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_acc)
        begin
            cost0_reg <= new0;
        end
        if (capture)
        begin
            out_dist_reg   <= tail.result_cost;
            out_within_reg <= (tail.result_cost <= max_distance_reg);
            out_num_reg    <= word_cnt_reg + edtf_pkg::NUM_W'(1);
            out_long_reg   <= overflow_reg;
        end
    end

    // The row of cells, one per query position.
    assign tok[0]  = head_tok_reg;
    assign busy[0] = head_tok_reg.valid;

    for (genvar i = 1; i <= MAX_QUERY; i++)
    begin : g_cell
        edtf_cell #(
            .IDX   (i),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .q_we    (q_we),
            .q_idx   (eff_len),
            .q_sym   (items.symbol),
            .len     (qlen_reg),
            .tok_in  (tok[i-1]),
            .tok_out (tok[i])
        );
        assign busy[i] = tok[i].valid;
    end

    assign results.valid          = out_valid_reg;
    assign results.distance       = out_dist_reg;
    assign results.within_limit   = out_within_reg;
    assign results.word_number    = out_num_reg;
    assign results.query_too_long = out_long_reg;

endmodule

// ===== src/edtf_checker.sv =====
// Port-level checks for the edit distance threshold filter, with the bind that
// attaches them to edit_distance_threshold_filter_top. Depends on edtf_pkg.
module edtf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_kind,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_distance,
    input logic        out_within,
    input logic [15:0] out_number,
    input logic        out_long
);

    logic in_acc;
    logic out_stall;

    assign in_acc    = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    // A result waiting to be taken keeps its transaction unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_stall |=> out_valid && $stable(out_distance) && $stable(out_within)
                      && $stable(out_number) && $stable(out_long))
        else $error("result changed while stalled");

    // Reset empties the output register at once.
    a_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result offered during reset");

    // A distance of zero is within any limit.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_distance == 8'd0)) |-> out_within)
        else $error("zero distance reported outside the limit");

    // The word that has just ended is still in the row, so no query symbol may follow at once.
    a_query_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_kind == edtf_pkg::KIND_DICT) && in_last)
        |=> !(in_acc && (in_kind == edtf_pkg::KIND_QUERY)))
        else $error("query symbol taken while a word was in flight");

endmodule

bind edit_distance_threshold_filter_top edtf_checker u_edtf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (items.valid),
    .in_ready     (items.ready),
    .in_kind      (items.kind),
    .in_last      (items.last),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_distance (results.distance),
    .out_within   (results.within_limit),
    .out_number   (results.word_number),
    .out_long     (results.query_too_long)
);
